### rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths, constants and types for the segment intersection trimmer.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int CW   = 24;          // coordinate width
  localparam int DW   = CW + 1;      // coordinate difference width
  localparam int PW   = 2 * DW;      // product width
  localparam int NW   = PW + 1;      // determinant and numerator width (signed)
  localparam int MW   = NW;          // magnitude width
  localparam int RW   = MW + 1;      // divider remainder width
  localparam int QF   = 24;          // fraction bits of t and u
  localparam int QW   = QF + 1;      // quotient bits kept: one integer bit
  localparam int TW   = QW + 2;      // signed width of t and u
  localparam int SHW  = PW + 1 - QF; // rounded step width
  localparam int SW   = CW + 4;      // point sum width

  localparam int LIM_W     = 21;
  localparam int TOL_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DW    = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL   = CFG_IDX_W'(1);

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1);
  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(17);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FRONT_N    = 4;

  localparam logic signed [TW-1:0] T_ONE   = TW'(2 ** QF);
  localparam logic signed [SW-1:0] SUM_MAX = SW'(2 ** (CW - 1) - 1);
  localparam logic signed [SW-1:0] SUM_MIN = SW'(-(2 ** (CW - 1)));
  localparam logic [PW:0]          HALF    = (PW + 1)'(2 ** (QF - 1));

  typedef struct packed {
    logic [LIM_W-1:0] limit;
    logic [TOL_W-1:0] tol;
  } cfg_t;

  typedef struct packed {
    logic                 rej;
    logic                 t_neg;
    logic                 u_neg;
    logic [MW-1:0]        dmag;
    logic [MW-1:0]        tmag;
    logic [MW-1:0]        umag;
    logic signed [CW-1:0] asx;
    logic signed [CW-1:0] asy;
    logic signed [DW-1:0] dx1;
    logic signed [DW-1:0] dy1;
    logic signed [CW-1:0] aex;
    logic signed [CW-1:0] aey;
    logic signed [CW-1:0] aez;
  } item_t;

  typedef struct packed {
    logic                 rej;
    logic                 t_neg;
    logic                 u_neg;
    logic signed [CW-1:0] asx;
    logic signed [CW-1:0] asy;
    logic signed [DW-1:0] dx1;
    logic signed [DW-1:0] dy1;
    logic signed [CW-1:0] aex;
    logic signed [CW-1:0] aey;
    logic signed [CW-1:0] aez;
  } side_t;

endpackage

### rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Forms direction vectors, determinant and numerators, and flags near-parallel
// pairs. Four registered stages.
// ----------------------------------------------------------------------------
module sit_front import sit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_vld_i,
  input  logic signed [CW-1:0] a_start_x_i,
  input  logic signed [CW-1:0] a_start_y_i,
  input  logic signed [CW-1:0] a_end_x_i,
  input  logic signed [CW-1:0] a_end_y_i,
  input  logic signed [CW-1:0] a_end_z_i,
  input  logic signed [CW-1:0] b_start_x_i,
  input  logic signed [CW-1:0] b_start_y_i,
  input  logic signed [CW-1:0] b_end_x_i,
  input  logic signed [CW-1:0] b_end_y_i,
  output logic [2:0]           inflight_o,
  output logic                 out_vld_o,
  output item_t                out_o
);

  typedef struct packed {
    logic signed [CW-1:0] asx;
    logic signed [CW-1:0] asy;
    logic signed [CW-1:0] aex;
    logic signed [CW-1:0] aey;
    logic signed [CW-1:0] aez;
  } pass_t;

  logic v1_q, v2_q, v3_q, v4_q;
  pass_t p1_q, p2_q, p3_q;

  logic signed [DW-1:0] dx1_q, dy1_q, dx2_q, dy2_q, ox_q, oy_q;
  logic signed [DW-1:0] dx1b_q, dy1b_q, dx1c_q, dy1c_q;
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [NW-1:0] det_q, tn_q, un_q;
  logic signed [NW-1:0] det_d, tn_d, un_d;
  logic [MW-1:0]        dmag_d, tmag_d, umag_d;
  item_t                item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: differences
  always_ff @(posedge clk_i) begin
    dx1_q  <= DW'(a_end_x_i) - DW'(a_start_x_i);
    dy1_q  <= DW'(a_end_y_i) - DW'(a_start_y_i);
    dx2_q  <= DW'(b_end_x_i) - DW'(b_start_x_i);
    dy2_q  <= DW'(b_end_y_i) - DW'(b_start_y_i);
    ox_q   <= DW'(b_start_x_i) - DW'(a_start_x_i);
    oy_q   <= DW'(b_start_y_i) - DW'(a_start_y_i);
    p1_q   <= '{asx: a_start_x_i, asy: a_start_y_i, aex: a_end_x_i,
                aey: a_end_y_i, aez: a_end_z_i};
  end

  // stage 2: cross products
  always_ff @(posedge clk_i) begin
    pa_q   <= dx1_q * dy2_q;
    pb_q   <= dy1_q * dx2_q;
    pc_q   <= ox_q * dy2_q;
    pd_q   <= oy_q * dx2_q;
    pe_q   <= ox_q * dy1_q;
    pf_q   <= oy_q * dx1_q;
    dx1b_q <= dx1_q;
    dy1b_q <= dy1_q;
    p2_q   <= p1_q;
  end

  assign det_d = NW'(pa_q) - NW'(pb_q);
  assign tn_d  = NW'(pc_q) - NW'(pd_q);
  assign un_d  = NW'(pe_q) - NW'(pf_q);

  // stage 3: determinant and numerators
  always_ff @(posedge clk_i) begin
    det_q  <= det_d;
    tn_q   <= tn_d;
    un_q   <= un_d;
    dx1c_q <= dx1b_q;
    dy1c_q <= dy1b_q;
    p3_q   <= p2_q;
  end

  assign dmag_d = det_q[NW-1] ? MW'(-det_q) : MW'(det_q);
  assign tmag_d = tn_q[NW-1]  ? MW'(-tn_q)  : MW'(tn_q);
  assign umag_d = un_q[NW-1]  ? MW'(-un_q)  : MW'(un_q);

  // stage 4: magnitudes and parallel test
  always_ff @(posedge clk_i) begin
    item_q.rej   <= (dmag_d == '0) || (dmag_d < MW'(cfg_i.limit));
    item_q.t_neg <= tn_q[NW-1] ^ det_q[NW-1];
    item_q.u_neg <= un_q[NW-1] ^ det_q[NW-1];
    item_q.dmag  <= dmag_d;
    item_q.tmag  <= tmag_d;
    item_q.umag  <= umag_d;
    item_q.asx   <= p3_q.asx;
    item_q.asy   <= p3_q.asy;
    item_q.dx1   <= dx1c_q;
    item_q.dy1   <= dy1c_q;
    item_q.aex   <= p3_q.aex;
    item_q.aey   <= p3_q.aey;
    item_q.aez   <= p3_q.aez;
  end

  assign inflight_o = 3'(v1_q) + 3'(v2_q) + 3'(v3_q) + 3'(v4_q);
  assign out_vld_o  = v4_q;
  assign out_o      = item_q;

endmodule

### rtl/sit_fifo.sv
// ----------------------------------------------------------------------------
// sit_fifo
// Short queue between front and back, registered read.
// ----------------------------------------------------------------------------
module sit_fifo import sit_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  item_t              push_data_i,
  output logic [FIFO_AW:0]   count_o,
  output logic               out_vld_o,
  output item_t              out_o
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               pop;
  logic               vld_q;
  item_t              rd_q;

  assign pop = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (pop) begin
      rd_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      vld_q    <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (FIFO_AW + 1)'(push_i) - (FIFO_AW + 1)'(pop);
      vld_q <= pop;
    end
  end

  assign count_o   = cnt_q;
  assign out_vld_o = vld_q;
  assign out_o     = rd_q;

endmodule

### rtl/sit_div.sv
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring divider: one quotient bit per stage, integer bit first.
// Flags quotients of two or more.
// ----------------------------------------------------------------------------
module sit_div import sit_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_vld_i,
  input  logic [MW-1:0] num_i,
  input  logic [MW-1:0] den_i,
  output logic          out_vld_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  logic          v_q   [QW+1];
  logic [RW-1:0] r_q   [QW+1];
  logic [MW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];

  always_ff @(posedge clk_i) begin
    r_q[0]   <= RW'(num_i);
    d_q[0]   <= den_i;
    q_q[0]   <= '0;
    ovf_q[0] <= ({1'b0, num_i} >= {den_i, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_vld_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_int
      assign trial = r_q[k];
    end else begin : g_frac
      assign trial = {r_q[k][RW-2:0], 1'b0};
    end

    assign ge = (trial >= RW'(d_q[k]));

    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= ge ? trial - RW'(d_q[k]) : trial;
      d_q[k+1]   <= d_q[k];
      q_q[k+1]   <= {q_q[k][QW-2:0], ge};
      ovf_q[k+1] <= ovf_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  assign out_vld_o = v_q[QW];
  assign quo_o     = q_q[QW];
  assign ovf_o     = ovf_q[QW];

endmodule

### rtl/sit_back.sv
// ----------------------------------------------------------------------------
// sit_back
// Divides out t and u, applies the range test, and moves along the first
// segment to the crossing point with rounding and saturation.
// ----------------------------------------------------------------------------
module sit_back import sit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_vld_i,
  input  item_t                in_i,
  output logic                 valid_o,
  output logic                 trimmed_o,
  output logic signed [CW-1:0] cut_x_o,
  output logic signed [CW-1:0] cut_y_o,
  output logic signed [CW-1:0] cut_z_o
);

  side_t         side_q [QW+1];
  logic          t_vld, u_vld;
  logic [QW-1:0] t_mag, u_mag;
  logic          t_ovf, u_ovf;

  sit_div u_div_t (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_vld_i),
    .num_i     (in_i.tmag),
    .den_i     (in_i.dmag),
    .out_vld_o (t_vld),
    .quo_o     (t_mag),
    .ovf_o     (t_ovf)
  );

  sit_div u_div_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (in_vld_i),
    .num_i     (in_i.umag),
    .den_i     (in_i.dmag),
    .out_vld_o (u_vld),
    .quo_o     (u_mag),
    .ovf_o     (u_ovf)
  );

  // side data travels alongside the dividers
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{rej: in_i.rej, t_neg: in_i.t_neg, u_neg: in_i.u_neg,
                   asx: in_i.asx, asy: in_i.asy, dx1: in_i.dx1, dy1: in_i.dy1,
                   aex: in_i.aex, aey: in_i.aey, aez: in_i.aez};
    for (int k = 0; k < QW; k++) begin
      side_q[k+1] <= side_q[k];
    end
  end

  // range test and products
  side_t                sd;
  logic signed [TW-1:0] tq, uq, tol_s, lo_s, hi_s;
  logic [DW-1:0]        dxm, dym;
  logic                 ok_d;

  assign sd    = side_q[QW];
  assign tq    = sd.t_neg ? -TW'(t_mag) : TW'(t_mag);
  assign uq    = sd.u_neg ? -TW'(u_mag) : TW'(u_mag);
  assign tol_s = TW'(cfg_i.tol);
  assign lo_s  = -tol_s;
  assign hi_s  = T_ONE + tol_s;
  assign dxm   = sd.dx1[DW-1] ? DW'(-sd.dx1) : DW'(sd.dx1);
  assign dym   = sd.dy1[DW-1] ? DW'(-sd.dy1) : DW'(sd.dy1);
  assign ok_d  = !sd.rej && !t_ovf && !u_ovf &&
                 (tq > lo_s) && (tq < hi_s) && (uq > lo_s) && (uq < hi_s);

  logic                 va_q, vb_q, vo_q;
  logic                 oka_q, okb_q;
  logic [PW-1:0]        px_q, py_q;
  logic                 nxa_q, nya_q, nxb_q, nyb_q;
  logic signed [CW-1:0] asxa_q, asya_q, aexa_q, aeya_q, aeza_q;
  logic signed [CW-1:0] asxb_q, asyb_q, aexb_q, aeyb_q, aezb_q;
  logic [SHW-1:0]       shx_q, shy_q;
  logic [PW:0]          rx, ry;

  always_ff @(posedge clk_i) begin
    oka_q  <= ok_d;
    px_q   <= t_mag * dxm;
    py_q   <= t_mag * dym;
    nxa_q  <= sd.t_neg ^ sd.dx1[DW-1];
    nya_q  <= sd.t_neg ^ sd.dy1[DW-1];
    asxa_q <= sd.asx;
    asya_q <= sd.asy;
    aexa_q <= sd.aex;
    aeya_q <= sd.aey;
    aeza_q <= sd.aez;
  end

  assign rx = {1'b0, px_q} + HALF;
  assign ry = {1'b0, py_q} + HALF;

  // round to the coordinate LSB, ties away from zero
  always_ff @(posedge clk_i) begin
    okb_q  <= oka_q;
    shx_q  <= rx[PW:QF];
    shy_q  <= ry[PW:QF];
    nxb_q  <= nxa_q;
    nyb_q  <= nya_q;
    asxb_q <= asxa_q;
    asyb_q <= asya_q;
    aexb_q <= aexa_q;
    aeyb_q <= aeya_q;
    aezb_q <= aeza_q;
  end

  logic signed [SW-1:0] shx_s, shy_s, sx, sy, satx, saty;

  assign shx_s = SW'(shx_q);
  assign shy_s = SW'(shy_q);
  assign sx    = nxb_q ? SW'(asxb_q) - shx_s : SW'(asxb_q) + shx_s;
  assign sy    = nyb_q ? SW'(asyb_q) - shy_s : SW'(asyb_q) + shy_s;
  assign satx  = (sx > SUM_MAX) ? SUM_MAX : ((sx < SUM_MIN) ? SUM_MIN : sx);
  assign saty  = (sy > SUM_MAX) ? SUM_MAX : ((sy < SUM_MIN) ? SUM_MIN : sy);

  logic                 trim_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i) begin
    trim_q <= okb_q;
    cx_q   <= okb_q ? CW'(satx) : aexb_q;
    cy_q   <= okb_q ? CW'(saty) : aeyb_q;
    cz_q   <= aezb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      va_q <= t_vld & u_vld;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  assign valid_o   = vo_q;
  assign trimmed_o = trim_q;
  assign cut_x_o   = cx_q;
  assign cut_y_o   = cy_q;
  assign cut_z_o   = cz_q;

endmodule

### rtl/segment_intersection_trim.sv
// A result passes the front stages, the queue, the t and u dividers and the back stages.
// Throughput: one pair per cycle while busy is low, set by the fully pipelined t
// and u dividers (one quotient bit per stage, 25 stages).
// The receiver cannot stall; busy only rises if the front queue would fill.
// Reset: asynchronous, active low; clears all valid flags, the queue and
// restores the parallel limit to 1 and the tolerance to 17.
// ----------------------------------------------------------------------------
// segment_intersection_trim
// Trims two 2D segments to their crossing point: front, queue and back.
// ----------------------------------------------------------------------------
module segment_intersection_trim import sit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  input  logic signed [CW-1:0] a_start_x_i,
  input  logic signed [CW-1:0] a_start_y_i,
  input  logic signed [CW-1:0] a_end_x_i,
  input  logic signed [CW-1:0] a_end_y_i,
  input  logic signed [CW-1:0] a_end_z_i,
  input  logic signed [CW-1:0] b_start_x_i,
  input  logic signed [CW-1:0] b_start_y_i,
  input  logic signed [CW-1:0] b_end_x_i,
  input  logic signed [CW-1:0] b_end_y_i,
  output logic                 valid_o,
  output logic                 trimmed_o,
  output logic signed [CW-1:0] cut_x_o,
  output logic signed [CW-1:0] cut_y_o,
  output logic signed [CW-1:0] cut_z_o
);

  cfg_t             cfg_q;
  logic [2:0]       inflight;
  logic [FIFO_AW:0] fifo_cnt;
  logic             f_vld, q_vld;
  item_t            f_item, q_item;
  logic             accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit <= LIMIT_RESET;
      cfg_q.tol   <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IDX_LIMIT: cfg_q.limit <= cfg_data_i[LIM_W-1:0];
        CFG_IDX_TOL:   cfg_q.tol   <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // hold off when queued plus in-flight words could overflow the queue
  assign busy   = ((FIFO_AW + 2)'(fifo_cnt) + (FIFO_AW + 2)'(inflight))
                  >= (FIFO_AW + 2)'(FIFO_DEPTH);
  assign accept = start && !busy;

  sit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_vld_i    (accept),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .a_end_z_i   (a_end_z_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .inflight_o  (inflight),
    .out_vld_o   (f_vld),
    .out_o       (f_item)
  );

  sit_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_vld),
    .push_data_i (f_item),
    .count_o     (fifo_cnt),
    .out_vld_o   (q_vld),
    .out_o       (q_item)
  );

  sit_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_vld_i  (q_vld),
    .in_i      (q_item),
    .valid_o   (valid_o),
    .trimmed_o (trimmed_o),
    .cut_x_o   (cut_x_o),
    .cut_y_o   (cut_y_o),
    .cut_z_o   (cut_z_o)
  );

endmodule
